// ===== hdl/spc_pkg.sv =====
// spc_pkg: widths and constants of the scheduled pump controller.
// No dependencies; referenced by the channel interfaces and imported by the controller and the bench.
package spc_pkg;

   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int START_W    = 11;
   localparam int RUN_W      = 8;
   localparam int DEFAULT_W  = 7;
   localparam int TIME_W     = 12;
   localparam int SEC_W      = 6;
   localparam int FULL_CNT_W = 3;
   localparam int EMPTY_CNT_W = 5;
   localparam int CSR_DATA_W = START_W;

   localparam logic [TIME_W-1:0]      MINUTES_PER_HOUR = 12'd60;
   localparam logic [SEC_W-1:0]       LAST_SECOND      = 6'd59;
   localparam logic [FULL_CNT_W-1:0]  FULL_HOLD        = 3'd5;
   localparam logic [EMPTY_CNT_W-1:0] EMPTY_HOLD       = 5'd20;
   localparam logic [DEFAULT_W-1:0]   DEFAULT_RESET    = 7'd30;

endpackage

// ===== hdl/spc_if.sv =====
// spc_req_if and spc_rsp_if: valid/ready channels of the pump controller.
// Depends on spc_pkg for the field widths.
interface spc_req_if;
   logic                          valid;
   logic                          ready;
   logic [spc_pkg::HOUR_W-1:0]    hour_of_day;
   logic [spc_pkg::MINUTE_W-1:0]  minute_of_hour;
   logic                          offline;
   logic                          full_sensor_active;
   logic                          empty_sensor_active;
   logic                          button_down;

   modport source (output valid, hour_of_day, minute_of_hour, offline,
                   full_sensor_active, empty_sensor_active, button_down,
                   input ready);
   modport sink (input valid, hour_of_day, minute_of_hour, offline,
                 full_sensor_active, empty_sensor_active, button_down,
                 output ready);
endinterface

interface spc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        motor_on;
   logic [spc_pkg::RUN_W-1:0]   shown_minutes;
   logic [spc_pkg::SEC_W-1:0]   shown_seconds;
   logic                        log_valid;
   logic [spc_pkg::RUN_W-1:0]   log_minutes;

   modport source (output valid, motor_on, shown_minutes, shown_seconds,
                   log_valid, log_minutes, input ready);
   modport sink (input valid, motor_on, shown_minutes, shown_seconds,
                 log_valid, log_minutes, output ready);
endinterface

// ===== hdl/scheduled_pump_controller_unit.sv =====
// scheduled_pump_controller_unit: tank pump controller stepped once per tick.
// Depends on spc_pkg and on spc_req_if / spc_rsp_if.
//
// Usage:
//   req_chan carries one tick request: time of day, offline flag, the two tank
//   sensors and the button level. rsp_chan returns one result per request:
//   motor drive, countdown shown before the decrement, and the run log.
//   csr_write/csr_index/csr_data write the window and default-length
//   registers; write them only while no request is in flight.
// Timing:
//   a request is registered on acceptance and its result is computed from the
//   request register straight into the result register. One request is taken
//   every cycle while rsp_chan is not stalled, set by the single pass of the
//   window match and countdown logic between the request and result registers.
// Reset:
//   synchronous; pump stopped, countdown at the default length, all windows
//   cleared, default length 30 minutes, both channels empty.
// Stall:
//   while rsp_chan is stalled the result holds; one more request is taken
//   into the request register, then req_chan.ready drops.
module scheduled_pump_controller_unit #(
   parameter int WINDOWS = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   spc_req_if.sink                            req_chan,
   spc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write,
   input  logic [$clog2(2*WINDOWS+1)-1:0]     csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import spc_pkg::*;

   localparam int IW = $clog2(2*WINDOWS+1);

   // configuration
   logic [START_W-1:0]   start_ff [WINDOWS];
   logic [RUN_W-1:0]     run_ff [WINDOWS];
   logic [DEFAULT_W-1:0] default_ff;

   // request register
   logic                 s1_valid_ff;
   logic [HOUR_W-1:0]    hour_ff;
   logic [MINUTE_W-1:0]  minute_ff;
   logic                 offline_ff;
   logic                 full_ff;
   logic                 empty_ff;
   logic                 button_ff;

   // pump state
   logic                    running_ff, running_in;
   logic [RUN_W-1:0]        cd_min_ff, cd_min_in;
   logic [SEC_W-1:0]        cd_sec_ff, cd_sec_in;
   logic [WINDOWS-1:0]      active_ff, active_in;
   logic [WINDOWS-1:0]      done_ff, done_in;
   logic [FULL_CNT_W-1:0]   full_cnt_ff, full_cnt_in;
   logic [EMPTY_CNT_W-1:0]  empty_cnt_ff, empty_cnt_in;
   logic                    button_last_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 motor_ff, motor_in;
   logic [RUN_W-1:0]     shown_min_ff, shown_min_in;
   logic [SEC_W-1:0]     shown_sec_ff, shown_sec_in;
   logic                 log_valid_ff, log_valid_in;
   logic [RUN_W-1:0]     log_min_ff, log_min_in;

   logic                 advance;
   logic [TIME_W-1:0]    now;
   logic [TIME_W-1:0]    win_end [WINDOWS];
   logic [WINDOWS-1:0]   in_window;
   logic [WINDOWS-1:0]   matched;
   logic                 matched_any;
   logic [RUN_W-1:0]     matched_left;
   logic [RUN_W-1:0]     active_run;
   logic                 press;
   logic                 stop;
   logic [FULL_CNT_W-1:0] full_inc;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.motor_on      = motor_ff;
   assign rsp_chan.shown_minutes = shown_min_ff;
   assign rsp_chan.shown_seconds = shown_sec_ff;
   assign rsp_chan.log_valid     = log_valid_ff;
   assign rsp_chan.log_minutes   = log_min_ff;

   // window match: first window holding the current minute wins
   always_comb begin
      now = TIME_W'(hour_ff) * MINUTES_PER_HOUR + TIME_W'(minute_ff);
      matched      = '0;
      matched_any  = 1'b0;
      matched_left = '0;
      for (int w = 0; w < WINDOWS; w++) begin
         win_end[w]   = TIME_W'(start_ff[w]) + TIME_W'(run_ff[w]);
         in_window[w] = (now >= TIME_W'(start_ff[w])) && (now < win_end[w]);
         if (in_window[w] && !matched_any && !offline_ff) begin
            matched[w]   = 1'b1;
            matched_any  = 1'b1;
            matched_left = RUN_W'(win_end[w] - now);
         end
      end
   end

   // one tick of the pump state
   always_comb begin
      press        = button_ff && !button_last_ff;
      running_in   = running_ff;
      cd_min_in    = cd_min_ff;
      cd_sec_in    = cd_sec_ff;
      active_in    = active_ff;
      done_in      = done_ff & in_window;
      full_cnt_in  = full_cnt_ff;
      empty_cnt_in = empty_cnt_ff;
      shown_min_in = '0;
      shown_sec_in = '0;
      log_valid_in = 1'b0;
      log_min_in   = '0;
      active_run   = '0;
      stop         = 1'b0;
      full_inc     = full_cnt_ff + 1'b1;

      if (press) begin
         if (!running_ff) begin
            running_in = 1'b1;
            cd_min_in  = RUN_W'(default_ff);
            cd_sec_in  = '0;
            active_in  = '0;
         end else if (active_ff == '0) begin
            running_in = 1'b0;
            cd_min_in  = RUN_W'(default_ff);
            cd_sec_in  = '0;
         end
      end

      if (!offline_ff && !running_in && matched_any && ((done_in & matched) == '0)) begin
         running_in = 1'b1;
         cd_min_in  = matched_left;
         cd_sec_in  = '0;
         active_in  = matched;
         done_in    = done_in | matched;
      end

      if (running_in) begin
         shown_min_in = cd_min_in;
         shown_sec_in = cd_sec_in;
         if (cd_sec_in != '0) begin
            cd_sec_in = cd_sec_in - 1'b1;
         end else if (cd_min_in != '0) begin
            cd_min_in = cd_min_in - 1'b1;
            cd_sec_in = LAST_SECOND;
         end
         if (full_ff) begin
            if (full_inc >= FULL_HOLD) begin
               full_cnt_in = '0;
               stop        = 1'b1;
            end else begin
               full_cnt_in = full_inc;
            end
         end else begin
            full_cnt_in = '0;
         end
         if (cd_min_in == '0 && cd_sec_in == '0) begin
            stop = 1'b1;
         end
         if (stop) begin
            running_in = 1'b0;
            cd_min_in  = RUN_W'(default_ff);
            cd_sec_in  = '0;
            done_in    = done_in | active_in;
            // length of the window that owns the run, even one started this tick
            for (int w = 0; w < WINDOWS; w++) begin
               if (active_in[w]) begin
                  active_run = active_run | run_ff[w];
               end
            end
            if (!offline_ff) begin
               log_valid_in = 1'b1;
               log_min_in   = (active_in != '0) ? active_run : RUN_W'(default_ff);
            end
         end
      end

      // low tank held long enough starts a default run
      if (empty_ff) begin
         if (empty_cnt_ff < EMPTY_HOLD) begin
            empty_cnt_in = empty_cnt_ff + 1'b1;
         end
         if (empty_cnt_in >= EMPTY_HOLD && !running_in) begin
            running_in = 1'b1;
            cd_min_in  = RUN_W'(default_ff);
            cd_sec_in  = '0;
            active_in  = '0;
         end
      end else begin
         empty_cnt_in = '0;
      end

      motor_in = running_in;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_ff     <= 1'b0;
         cd_min_ff      <= RUN_W'(DEFAULT_RESET);
         cd_sec_ff      <= '0;
         active_ff      <= '0;
         done_ff        <= '0;
         full_cnt_ff    <= '0;
         empty_cnt_ff   <= '0;
         button_last_ff <= 1'b0;
         default_ff     <= DEFAULT_RESET;
         for (int w = 0; w < WINDOWS; w++) begin
            start_ff[w] <= '0;
            run_ff[w]   <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            running_ff     <= running_in;
            cd_min_ff      <= cd_min_in;
            cd_sec_ff      <= cd_sec_in;
            active_ff      <= active_in;
            done_ff        <= done_in;
            full_cnt_ff    <= full_cnt_in;
            empty_cnt_ff   <= empty_cnt_in;
            button_last_ff <= button_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            for (int w = 0; w < WINDOWS; w++) begin
               if (csr_index == IW'(2*w)) begin
                  start_ff[w] <= csr_data[START_W-1:0];
               end
               if (csr_index == IW'(2*w+1)) begin
                  run_ff[w] <= csr_data[RUN_W-1:0];
               end
            end
            if (csr_index == IW'(2*WINDOWS)) begin
               default_ff <= csr_data[DEFAULT_W-1:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         hour_ff   <= req_chan.hour_of_day;
         minute_ff <= req_chan.minute_of_hour;
         offline_ff <= req_chan.offline;
         full_ff   <= req_chan.full_sensor_active;
         empty_ff  <= req_chan.empty_sensor_active;
         button_ff <= req_chan.button_down;
      end
      if (advance) begin
         motor_ff     <= motor_in;
         shown_min_ff <= shown_min_in;
         shown_sec_ff <= shown_sec_in;
         log_valid_ff <= log_valid_in;
         log_min_ff   <= log_min_in;
      end
   end

   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      cd_sec_ff <= LAST_SECOND)
      else $error("countdown seconds out of range");

   a_active_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_ff))
      else $error("more than one active window");

   a_full_range: assert property (@(posedge clock) disable iff (reset)
      full_cnt_ff < FULL_HOLD)
      else $error("full counter passed its hold");

   a_empty_range: assert property (@(posedge clock) disable iff (reset)
      empty_cnt_ff <= EMPTY_HOLD)
      else $error("empty counter passed its hold");

   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff)
      else $error("stalled result dropped");

endmodule

// ===== bench/pump_check_pkg.sv =====
`timescale 1ns / 1ps
// pump_check_pkg: request/result types and the tick-by-tick scoreboard of the
// scheduled pump controller bench. Depends on spc_pkg for the field widths.
package pump_check_pkg;
   import spc_pkg::*;

   localparam int NUM_WINDOWS = 3;
   localparam int NUM_REGS    = 2 * NUM_WINDOWS + 1;
   localparam int unsigned NO_WINDOW       = NUM_WINDOWS;
   localparam int unsigned MIN_PER_HOUR    = 60;
   localparam int unsigned TICKS_PER_MIN   = 60;
   localparam int unsigned FULL_STOP_TICKS = 5;
   localparam int unsigned LOW_START_TICKS = 20;
   localparam int unsigned COUNT_MASK      = 32'h3FFF;
   localparam int unsigned MAX_REPORTS     = 30;

   typedef enum logic [2:0] {
      REG_START_A, REG_RUN_A, REG_START_B, REG_RUN_B, REG_START_C, REG_RUN_C, REG_DEFAULT
   } csr_reg_e;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour_of_day;
      logic [MINUTE_W-1:0] minute_of_hour;
      logic                offline;
      logic                full_sensor_active;
      logic                empty_sensor_active;
      logic                button_down;
   } tick_t;

   typedef struct packed {
      logic              motor_on;
      logic [RUN_W-1:0]  shown_minutes;
      logic [SEC_W-1:0]  shown_seconds;
      logic              log_valid;
      logic [RUN_W-1:0]  log_minutes;
   } pump_result_t;

   class pump_tick_scoreboard;
      logic [START_W-1:0]   start_minute [NUM_WINDOWS];
      logic [RUN_W-1:0]     run_minutes [NUM_WINDOWS];
      logic [DEFAULT_W-1:0] default_minutes;
      bit                   running;
      int unsigned          countdown;
      int unsigned          active_window;
      bit                   window_done [NUM_WINDOWS];
      int unsigned          full_count;
      int unsigned          empty_count;
      bit                   button_last;
      pump_result_t         pending_results [$];
      int unsigned          failures;
      int unsigned          reported;

      function new();
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            start_minute[w] = '0;
            run_minutes[w]  = '0;
            window_done[w]  = 1'b0;
         end
         default_minutes = DEFAULT_RESET;
         running         = 1'b0;
         countdown       = default_ticks();
         active_window   = NO_WINDOW;
         full_count      = 0;
         empty_count     = 0;
         button_last     = 1'b0;
         failures        = 0;
         reported        = 0;
      endfunction

      function int unsigned default_ticks();
         return (int'(default_minutes) * TICKS_PER_MIN) & COUNT_MASK;
      endfunction

      function void start_default_run();
         running       = 1'b1;
         countdown     = default_ticks();
         active_window = NO_WINDOW;
      endfunction

      function void write_reg(csr_reg_e idx, logic [CSR_DATA_W-1:0] value);
         int w;
         if (idx == REG_DEFAULT) begin
            default_minutes = value[DEFAULT_W-1:0];
         end else begin
            // even index is a window start, odd its length
            w = int'(idx) / 2;
            if (int'(idx) % 2 == 0) start_minute[w] = value[START_W-1:0];
            else run_minutes[w] = value[RUN_W-1:0];
         end
      endfunction

      function void note_tick(tick_t t);
         int unsigned  now;
         int unsigned  fin;
         int unsigned  matched;
         bit           in_win;
         bit           stop;
         pump_result_t r;
         now     = int'(t.hour_of_day) * MIN_PER_HOUR + int'(t.minute_of_hour);
         matched = NO_WINDOW;
         r       = '0;
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            fin    = int'(start_minute[w]) + int'(run_minutes[w]);
            in_win = (now >= start_minute[w]) && (now < fin);
            if (in_win && matched == NO_WINDOW && !t.offline) matched = w;
            if (!in_win) window_done[w] = 1'b0;
         end
         if (t.button_down && !button_last) begin
            if (!running) begin
               start_default_run();
            end else if (active_window == NO_WINDOW) begin
               running   = 1'b0;
               countdown = default_ticks();
            end
         end
         button_last = t.button_down;
         if (!t.offline && !running && matched != NO_WINDOW && !window_done[matched]) begin
            fin           = int'(start_minute[matched]) + int'(run_minutes[matched]);
            running       = 1'b1;
            countdown     = ((fin - now) * TICKS_PER_MIN) & COUNT_MASK;
            active_window = matched;
            window_done[matched] = 1'b1;
         end
         if (running) begin
            stop            = 1'b0;
            r.shown_minutes = RUN_W'(countdown / TICKS_PER_MIN);
            r.shown_seconds = SEC_W'(countdown % TICKS_PER_MIN);
            if (countdown > 0) countdown--;
            if (t.full_sensor_active) begin
               full_count++;
               if (full_count >= FULL_STOP_TICKS) begin
                  full_count = 0;
                  stop       = 1'b1;
               end
            end else begin
               full_count = 0;
            end
            if (countdown == 0) stop = 1'b1;
            if (stop) begin
               running   = 1'b0;
               countdown = default_ticks();
               if (active_window != NO_WINDOW) window_done[active_window] = 1'b1;
               if (!t.offline) begin
                  r.log_valid   = 1'b1;
                  r.log_minutes = (active_window != NO_WINDOW) ? run_minutes[active_window]
                                                               : RUN_W'(default_minutes);
               end
            end
         end
         if (t.empty_sensor_active) begin
            if (empty_count < LOW_START_TICKS) empty_count++;
            // low tank restarts the pump even in the tick a run just ended
            if (empty_count >= LOW_START_TICKS && !running) start_default_run();
         end else begin
            empty_count = 0;
         end
         r.motor_on = running;
         pending_results.push_back(r);
      endfunction

      function void check_result(pump_result_t got);
         pump_result_t want;
         if (pending_results.size() == 0) begin
            failures++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("%0t: result with no request pending, expected none, actual %h",
                        $time, got);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            failures++;
            if (reported < MAX_REPORTS) begin
               reported++;
               if (got.motor_on !== want.motor_on)
                  $display("%0t: motor_on expected %0d actual %0d",
                           $time, want.motor_on, got.motor_on);
               if (got.shown_minutes !== want.shown_minutes)
                  $display("%0t: shown_minutes expected %0d actual %0d",
                           $time, want.shown_minutes, got.shown_minutes);
               if (got.shown_seconds !== want.shown_seconds)
                  $display("%0t: shown_seconds expected %0d actual %0d",
                           $time, want.shown_seconds, got.shown_seconds);
               if (got.log_valid !== want.log_valid)
                  $display("%0t: log_valid expected %0d actual %0d",
                           $time, want.log_valid, got.log_valid);
               if (got.log_minutes !== want.log_minutes)
                  $display("%0t: log_minutes expected %0d actual %0d",
                           $time, want.log_minutes, got.log_minutes);
            end
         end
      endfunction
   endclass

endpackage

// ===== bench/tb_scheduled_pump_controller_unit.sv =====
`timescale 1ns / 1ps
// tb_scheduled_pump_controller_unit: drives tick requests and register phases
// into the pump controller and checks every result against the scoreboard.
// Depends on spc_pkg, spc_req_if / spc_rsp_if and pump_check_pkg.
module tb_scheduled_pump_controller_unit;
   import spc_pkg::*;
   import pump_check_pkg::*;

   localparam int NUM_PHASES  = 6;
   localparam int PHASE_TICKS = 222;
   localparam int OPENING_LEN = 21;

   // hour, minute, offline, full, empty, button
   localparam tick_t OPENING [OPENING_LEN] = '{
      '{5'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{5'd23, 6'd59, 1'b0, 1'b0, 1'b0, 1'b1},
      '{5'd31, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0},
      '{5'd16, 6'd32, 1'b0, 1'b0, 1'b0, 1'b1},
      '{5'd15, 6'd31, 1'b1, 1'b0, 1'b0, 1'b0},
      '{5'd8,  6'd1,  1'b1, 1'b0, 1'b0, 1'b1},
      '{5'd1,  6'd2,  1'b1, 1'b1, 1'b0, 1'b1},
      '{5'd1,  6'd2,  1'b1, 1'b1, 1'b0, 1'b1},
      '{5'd1,  6'd2,  1'b1, 1'b1, 1'b0, 1'b1},
      '{5'd1,  6'd2,  1'b1, 1'b1, 1'b0, 1'b1},
      '{5'd1,  6'd2,  1'b1, 1'b1, 1'b0, 1'b1},
      '{5'd2,  6'd4,  1'b0, 1'b1, 1'b0, 1'b0},
      '{5'd4,  6'd8,  1'b0, 1'b0, 1'b0, 1'b1},
      '{5'd0,  6'd16, 1'b0, 1'b1, 1'b0, 1'b1},
      '{5'd0,  6'd16, 1'b0, 1'b1, 1'b0, 1'b1},
      '{5'd0,  6'd16, 1'b0, 1'b1, 1'b0, 1'b1},
      '{5'd0,  6'd16, 1'b0, 1'b1, 1'b0, 1'b1},
      '{5'd0,  6'd16, 1'b0, 1'b1, 1'b0, 1'b1},
      '{5'd0,  6'd0,  1'b0, 1'b0, 1'b1, 1'b0},
      '{5'd31, 6'd0,  1'b0, 1'b1, 1'b1, 1'b1},
      '{5'd0,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_write;
   logic [$clog2(2*NUM_WINDOWS+1)-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]                 csr_data;

   spc_req_if req_chan ();
   spc_rsp_if rsp_chan ();

   pump_tick_scoreboard sb = new();

   // stimulus shaping state
   int unsigned          hold_left;
   int unsigned          full_left;
   int unsigned          empty_left;
   int unsigned          burst_left;
   logic [HOUR_W-1:0]    cur_hour;
   logic [MINUTE_W-1:0]  cur_minute;
   bit                   full_level;
   bit                   empty_level;
   bit                   button_level;
   bit                   offline_level;

   scheduled_pump_controller_unit #(.WINDOWS(NUM_WINDOWS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin : monitor
      tick_t        seen_tick;
      pump_result_t seen_result;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_result.motor_on      = rsp_chan.motor_on;
            seen_result.shown_minutes = rsp_chan.shown_minutes;
            seen_result.shown_seconds = rsp_chan.shown_seconds;
            seen_result.log_valid     = rsp_chan.log_valid;
            seen_result.log_minutes   = rsp_chan.log_minutes;
            sb.check_result(seen_result);
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_tick.hour_of_day         = req_chan.hour_of_day;
            seen_tick.minute_of_hour      = req_chan.minute_of_hour;
            seen_tick.offline             = req_chan.offline;
            seen_tick.full_sensor_active  = req_chan.full_sensor_active;
            seen_tick.empty_sensor_active = req_chan.empty_sensor_active;
            seen_tick.button_down         = req_chan.button_down;
            sb.note_tick(seen_tick);
         end
      end
   end

   initial begin : rsp_stall_pattern
      int unsigned open_len;
      int unsigned shut_len;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         open_len = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
         shut_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         rsp_chan.ready <= 1'b1;
         repeat (open_len) @(posedge clock);
         if (shut_len != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (shut_len) @(posedge clock);
         end
      end
   end

   task automatic send_tick(input tick_t t);
      req_chan.valid               <= 1'b1;
      req_chan.hour_of_day         <= t.hour_of_day;
      req_chan.minute_of_hour      <= t.minute_of_hour;
      req_chan.offline             <= t.offline;
      req_chan.full_sensor_active  <= t.full_sensor_active;
      req_chan.empty_sensor_active <= t.empty_sensor_active;
      req_chan.button_down         <= t.button_down;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_phase_config(input int phase);
      logic [CSR_DATA_W-1:0] vals [NUM_REGS];
      int unsigned           base;
      for (int w = 0; w < NUM_WINDOWS; w++) begin
         vals[REG_START_A + 2*w] = CSR_DATA_W'($urandom_range(0, 1439));
         vals[REG_RUN_A + 2*w]   = CSR_DATA_W'($urandom_range(1, 6));
      end
      vals[REG_DEFAULT] = CSR_DATA_W'($urandom_range(1, 100));
      case (phase)
         1: begin
            // widest windows, one at the top of the day, one never reachable
            vals[REG_START_A] = CSR_DATA_W'(0);
            vals[REG_START_B] = CSR_DATA_W'(1439);
            vals[REG_START_C] = CSR_DATA_W'(2047);
            vals[REG_RUN_A]   = CSR_DATA_W'(255);
            vals[REG_RUN_B]   = CSR_DATA_W'(255);
            vals[REG_RUN_C]   = CSR_DATA_W'(255);
            vals[REG_DEFAULT] = CSR_DATA_W'(100);
         end
         2: vals[REG_DEFAULT] = CSR_DATA_W'(0);   // zero-length runs stop on their first tick
         3: begin
            vals[REG_DEFAULT] = CSR_DATA_W'(127);
            vals[REG_RUN_B]   = CSR_DATA_W'(0);
         end
         4: begin
            // overlapping windows, first match wins
            base = $urandom_range(0, 1400);
            vals[REG_START_A] = CSR_DATA_W'(base);
            vals[REG_START_B] = CSR_DATA_W'(base);
            vals[REG_START_C] = CSR_DATA_W'(base + 1);
            vals[REG_DEFAULT] = CSR_DATA_W'(1);
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_reg_e'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         sb.write_reg(csr_reg_e'(i), vals[i]);
      end
      csr_write <= 1'b0;
   endtask

   function automatic void next_tick(output tick_t t);
      int unsigned w;
      int unsigned s;
      int unsigned r;
      int unsigned now;
      if (hold_left == 0) begin
         hold_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 30);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // aim at the edges of a configured window
               w = $urandom_range(0, NUM_WINDOWS - 1);
               s = sb.start_minute[w];
               r = sb.run_minutes[w];
               case ($urandom_range(0, 4))
                  0: now = s;
                  1: now = (r != 0) ? s + r - 1 : s;
                  2: now = s + r;
                  3: now = (s != 0) ? s - 1 : s;
                  default: now = s + $urandom_range(0, r);
               endcase
               cur_hour   = HOUR_W'(now / MIN_PER_HOUR);
               cur_minute = MINUTE_W'(now % MIN_PER_HOUR);
            end
            6, 7: begin
               now        = $urandom_range(0, 1439);
               cur_hour   = HOUR_W'(now / MIN_PER_HOUR);
               cur_minute = MINUTE_W'(now % MIN_PER_HOUR);
            end
            default: begin
               cur_hour   = HOUR_W'($urandom_range(0, 31));
               cur_minute = MINUTE_W'($urandom_range(0, 63));
            end
         endcase
      end
      hold_left--;
      if (full_left == 0) begin
         full_level = !full_level;
         full_left  = full_level ? $urandom_range(1, 7) : $urandom_range(1, 30);
      end
      full_left--;
      if (empty_left == 0) begin
         empty_level = !empty_level;
         empty_left  = empty_level ? $urandom_range(1, 26) : $urandom_range(1, 40);
      end
      empty_left--;
      if ($urandom_range(0, 11) == 0) button_level = !button_level;
      if ($urandom_range(0, offline_level ? 5 : 49) == 0) offline_level = !offline_level;
      t.hour_of_day         = cur_hour;
      t.minute_of_hour      = cur_minute;
      t.offline             = offline_level;
      t.full_sensor_active  = full_level;
      t.empty_sensor_active = empty_level;
      t.button_down         = button_level;
   endfunction

   initial begin : stimulus
      tick_t       t;
      int unsigned gap;
      reset                        <= 1'b1;
      csr_write                    <= 1'b0;
      csr_index                    <= '0;
      csr_data                     <= '0;
      req_chan.valid               <= 1'b0;
      req_chan.hour_of_day         <= '0;
      req_chan.minute_of_hour      <= '0;
      req_chan.offline             <= 1'b0;
      req_chan.full_sensor_active  <= 1'b0;
      req_chan.empty_sensor_active <= 1'b0;
      req_chan.button_down         <= 1'b0;
      hold_left     = 0;
      full_left     = 0;
      empty_left    = 0;
      burst_left    = 0;
      cur_hour      = '0;
      cur_minute    = '0;
      full_level    = 1'b1;
      empty_level   = 1'b1;
      button_level  = 1'b0;
      offline_level = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < OPENING_LEN; i++) send_tick(OPENING[i]);
      button_level = OPENING[OPENING_LEN-1].button_down;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) begin
            wait_drained();
            load_phase_config(phase);
         end
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               if (gap != 0) begin
                  req_chan.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            end
            burst_left--;
            next_tick(t);
            send_tick(t);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
